FILE: design/safe_box_grower_assert.svh
// Assertion macros for the safe box grower design files.
`ifndef SAFE_BOX_GROWER_ASSERT_SVH
`define SAFE_BOX_GROWER_ASSERT_SVH
// Assert an implication on every rising clock edge outside reset.
`define SBG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Assert an implication whose consequent is checked in the following cycle.
`define SBG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: design/sbg_pkg.sv
// Package with shared types and constants of the safe box grower.
package sbg_pkg;
  localparam int unsigned CfgAddrBits = 5;
  localparam int unsigned CfgDataBits = 32;
  localparam int unsigned RadiusBits  = 16;
  localparam int unsigned MapBits     = 19;
  localparam int unsigned CountBits   = 7;
  localparam int unsigned SlotBits    = 6;

  localparam logic [2:0] RegMapWidth  = 3'd0;
  localparam logic [2:0] RegMapHeight = 3'd1;
  localparam logic [2:0] RegVehRadius = 3'd2;
  localparam logic [2:0] RegStepSize  = 3'd3;
  localparam logic [2:0] RegSideLimit = 3'd4;
  localparam logic [2:0] RegObsCount  = 3'd5;

  localparam logic OpLoad = 1'b0;
  localparam logic OpGrow = 1'b1;

  typedef enum logic [1:0] {
    SidePosY = 2'd0,
    SideNegX = 2'd1,
    SideNegY = 2'd2,
    SidePosX = 2'd3
  } side_e;

  typedef struct packed {
    logic [MapBits-1:0]    map_width;
    logic [MapBits-1:0]    map_height;
    logic [RadiusBits-1:0] vehicle_radius;
    logic [RadiusBits-1:0] step_size;
    logic [MapBits-1:0]    side_limit;
    logic [CountBits-1:0]  obstacle_count;
  } cfg_t;
endpackage

FILE: design/sbg_if.sv
// Valid/ready channel interfaces for input and result words.
interface sbg_in_if #(parameter int unsigned COORD_BITS = 20);
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [5:0]                   slot;
  logic signed [COORD_BITS-1:0] obstacle_x;
  logic signed [COORD_BITS-1:0] obstacle_y;
  logic [15:0]                  obstacle_radius;
  logic signed [COORD_BITS-1:0] seed_x;
  logic signed [COORD_BITS-1:0] seed_y;
  modport source (output valid, op, slot, obstacle_x, obstacle_y, obstacle_radius,
                  seed_x, seed_y, input ready);
  modport sink (input valid, op, slot, obstacle_x, obstacle_y, obstacle_radius,
                seed_x, seed_y, output ready);
endinterface

interface sbg_out_if #(parameter int unsigned COORD_BITS = 20);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] box_x_min;
  logic signed [COORD_BITS-1:0] box_x_max;
  logic signed [COORD_BITS-1:0] box_y_min;
  logic signed [COORD_BITS-1:0] box_y_max;
  logic                         grew;
  modport source (output valid, box_x_min, box_x_max, box_y_min, box_y_max, grew,
                  input ready);
  modport sink (input valid, box_x_min, box_x_max, box_y_min, box_y_max, grew,
                output ready);
endinterface

FILE: design/sbg_ram.sv
// Generic single-port synchronous RAM with registered read.
module sbg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: design/sbg_cfg.sv
// APB configuration register file of the safe box grower.
module sbg_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sbg_pkg::CfgAddrBits-1:0] paddr,
  input  logic [sbg_pkg::CfgDataBits-1:0] pwdata,
  output logic [sbg_pkg::CfgDataBits-1:0] prdata,
  output logic                            pready,
  output sbg_pkg::cfg_t                   cfg_o
);
  import sbg_pkg::*;

  cfg_t        cfg_q;
  logic        wr_en;
  logic [2:0]  reg_idx;
  logic        addr_hit;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[4:2];
  assign addr_hit = (paddr[1:0] == 2'b00);
  assign wr_en    = psel && penable && pwrite && addr_hit;
  assign cfg_o    = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.map_width      <= MapBits'(25600);
      cfg_q.map_height     <= MapBits'(25600);
      cfg_q.vehicle_radius <= RadiusBits'(256);
      cfg_q.step_size      <= RadiusBits'(26);
      cfg_q.side_limit     <= MapBits'(1280);
      cfg_q.obstacle_count <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        RegMapWidth:  cfg_q.map_width      <= pwdata[MapBits-1:0];
        RegMapHeight: cfg_q.map_height     <= pwdata[MapBits-1:0];
        RegVehRadius: cfg_q.vehicle_radius <= pwdata[RadiusBits-1:0];
        RegStepSize:  cfg_q.step_size      <= pwdata[RadiusBits-1:0];
        RegSideLimit: cfg_q.side_limit     <= pwdata[MapBits-1:0];
        RegObsCount:  cfg_q.obstacle_count <= pwdata[CountBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (addr_hit) begin
      case (reg_idx)
        RegMapWidth:  prdata = CfgDataBits'(cfg_q.map_width);
        RegMapHeight: prdata = CfgDataBits'(cfg_q.map_height);
        RegVehRadius: prdata = CfgDataBits'(cfg_q.vehicle_radius);
        RegStepSize:  prdata = CfgDataBits'(cfg_q.step_size);
        RegSideLimit: prdata = CfgDataBits'(cfg_q.side_limit);
        RegObsCount:  prdata = CfgDataBits'(cfg_q.obstacle_count);
        default:      prdata = '0;
      endcase
    end
  end
endmodule

FILE: design/sbg_engine.sv
// Box growth sequencer: one obstacle table entry tested per cycle.
module sbg_engine #(
  parameter int unsigned MAX_OBSTACLES = 64,
  parameter int unsigned COORD_BITS    = 20
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sbg_pkg::cfg_t cfg_i,
  sbg_in_if.sink        in_if,
  sbg_out_if.source     out_if
);
  import sbg_pkg::*;

  localparam int unsigned AW  = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int unsigned CW  = $clog2(MAX_OBSTACLES + 1);
  localparam int unsigned EW  = 2 * COORD_BITS + RadiusBits;
  // Wide enough for coordinates plus step, radii and map extents.
  localparam int unsigned WW  = ((COORD_BITS > MapBits) ? COORD_BITS : MapBits) + 3;

  typedef enum logic [2:0] {
    StIdle,
    StTrial,
    StScan,
    StDecide,
    StDone
  } state_e;

  typedef logic signed [WW-1:0] wide_t;

  state_e      state_q;
  wide_t       box_q [4];   // 0 x_min, 1 y_min, 2 x_max, 3 y_max
  wide_t       trial_q [4];
  wide_t       len_q [4];
  logic [3:0]  active_q;
  side_e       side_q;
  logic        grew_q;
  logic        safe_q;
  logic [CW-1:0] idx_q;
  logic [CW-1:0] n_eff;
  logic        rd_pend_q;

  logic        ram_we;
  logic [AW-1:0] ram_addr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;

  wide_t       rv, step, ox, oy, od;
  logic        hit;
  logic        map_ok;
  logic        in_fire;
  logic        slot_ok;

  assign in_fire = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == StIdle) && !out_if.valid;
  assign slot_ok = (MAX_OBSTACLES >= 64) ||
                   ({26'd0, in_if.slot} < 32'(MAX_OBSTACLES));

  assign n_eff = (32'(cfg_i.obstacle_count) > 32'(MAX_OBSTACLES)) ?
                 CW'(MAX_OBSTACLES) :
                 CW'(cfg_i.obstacle_count);

  assign ram_we    = in_fire && (in_if.op == OpLoad) && slot_ok;
  assign ram_wdata = {in_if.obstacle_x, in_if.obstacle_y, in_if.obstacle_radius};
  assign ram_addr  = (state_q == StIdle) ? AW'(in_if.slot) : idx_q[AW-1:0];

  sbg_ram #(.WIDTH(EW), .DEPTH(MAX_OBSTACLES)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign rv   = wide_t'(cfg_i.vehicle_radius);
  assign step = wide_t'(cfg_i.step_size);
  assign ox   = wide_t'($signed(ram_rdata[EW-1 -: COORD_BITS]));
  assign oy   = wide_t'($signed(ram_rdata[RadiusBits +: COORD_BITS]));
  assign od   = wide_t'(ram_rdata[RadiusBits-1:0]) + rv;
  assign hit  = (trial_q[0] - od < ox) && (ox < trial_q[2] + od) &&
                (trial_q[1] - od < oy) && (oy < trial_q[3] + od);
  assign map_ok = (trial_q[0] >= rv) && (trial_q[1] >= rv) &&
                  (trial_q[2] <= wide_t'(cfg_i.map_width) - rv) &&
                  (trial_q[3] <= wide_t'(cfg_i.map_height) - rv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      out_if.valid <= 1'b0;
      active_q     <= '0;
      side_q       <= SidePosY;
      grew_q       <= 1'b0;
      safe_q       <= 1'b0;
      idx_q        <= '0;
      rd_pend_q    <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        out_if.valid <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            if (in_if.op == OpLoad) begin
              out_if.box_x_min <= '0;
              out_if.box_x_max <= '0;
              out_if.box_y_min <= '0;
              out_if.box_y_max <= '0;
              out_if.grew      <= 1'b1;
              out_if.valid     <= 1'b1;
            end else begin
              box_q[0] <= wide_t'(in_if.seed_x);
              box_q[2] <= wide_t'(in_if.seed_x);
              box_q[1] <= wide_t'(in_if.seed_y);
              box_q[3] <= wide_t'(in_if.seed_y);
              for (int i = 0; i < 4; i++) len_q[i] <= '0;
              active_q <= 4'hF;
              side_q   <= SidePosY;
              grew_q   <= 1'b0;
              state_q  <= StTrial;
            end
          end
        end
        StTrial: begin
          // Build the trial box for the current side, skip inactive sides, finish when none is left.
          if (active_q == 4'h0) begin
            state_q <= StDone;
          end else if (!active_q[side_q]) begin
            side_q <= side_e'(side_q + 2'd1);
          end else begin
            trial_q[0] <= (side_q == SideNegX) ? box_q[0] - step : box_q[0];
            trial_q[1] <= (side_q == SideNegY) ? box_q[1] - step : box_q[1];
            trial_q[2] <= (side_q == SidePosX) ? box_q[2] + step : box_q[2];
            trial_q[3] <= (side_q == SidePosY) ? box_q[3] + step : box_q[3];
            safe_q    <= (cfg_i.step_size != '0);
            idx_q     <= '0;
            rd_pend_q <= 1'b0;
            state_q   <= StScan;
          end
        end
        StScan: begin
          // Address idx_q is presented; its data arrives in the following cycle.
          if (rd_pend_q && hit) begin
            safe_q <= 1'b0;
          end
          if (idx_q < n_eff) begin
            idx_q     <= idx_q + CW'(1);
            rd_pend_q <= 1'b1;
          end else begin
            rd_pend_q <= 1'b0;
            state_q   <= StDecide;
          end
        end
        StDecide: begin
          if (safe_q && map_ok) begin
            for (int i = 0; i < 4; i++) box_q[i] <= trial_q[i];
            grew_q <= 1'b1;
            len_q[side_q] <= len_q[side_q] + step;
            if (len_q[side_q] + step >= wide_t'(cfg_i.side_limit)) begin
              active_q[side_q] <= 1'b0;
            end
          end else begin
            active_q[side_q] <= 1'b0;
          end
          side_q  <= side_e'(side_q + 2'd1);
          state_q <= StTrial;
        end
        StDone: begin
          out_if.box_x_min <= box_q[0][COORD_BITS-1:0];
          out_if.box_x_max <= box_q[2][COORD_BITS-1:0];
          out_if.box_y_min <= box_q[1][COORD_BITS-1:0];
          out_if.box_y_max <= box_q[3][COORD_BITS-1:0];
          out_if.grew      <= grew_q;
          out_if.valid     <= 1'b1;
          state_q          <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `include "safe_box_grower_assert.svh"
  `SBG_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, state_q != StIdle, !in_if.ready, "input accepted while busy")
  `SBG_ASSERT_NEXT(a_done_emits, clk_i, rst_ni, state_q == StDone, out_if.valid, "query finished without a result")
  `SBG_ASSERT_IMP(a_scan_bound, clk_i, rst_ni, state_q == StScan, idx_q <= n_eff, "scan index past table count")
endmodule

FILE: design/safe_box_grower.sv
// Top level of the safe box grower: config port, obstacle table and growth engine.
//
//  channel | dir | handshake    | word
//  in_if   | in  | valid/ready  | op, slot, obstacle fields, seed point
//  out_if  | out | valid/ready  | box bounds and grew flag
//  apb     | in  | psel/penable | register writes and reads, pready tied high
//
// A load writes its table slot and returns a result word. Each query trial sweeps
// the counted obstacle entries through the single RAM port, one entry per cycle.
// Reset clears control state; table contents stay undefined until loaded.
// A stalled result blocks new words until it is taken.
module safe_box_grower #(
  parameter int unsigned MAX_OBSTACLES = 64,
  parameter int unsigned COORD_BITS    = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sbg_pkg::CfgAddrBits-1:0] paddr,
  input  logic [sbg_pkg::CfgDataBits-1:0] pwdata,
  output logic [sbg_pkg::CfgDataBits-1:0] prdata,
  output logic                            pready,
  sbg_in_if.sink                          in_if,
  sbg_out_if.source                       out_if
);
  import sbg_pkg::*;

  cfg_t cfg;

  // Hold the configuration registers.
  sbg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Run loads and box growth against the obstacle table.
  sbg_engine #(.MAX_OBSTACLES(MAX_OBSTACLES), .COORD_BITS(COORD_BITS)) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_if  (in_if),
    .out_if (out_if)
  );
endmodule

FILE: verif/tb_safe_box_grower.sv
// Self-checking bench for safe_box_grower: directed and random loads and box queries against a predictor.
module tb_safe_box_grower;
  import sbg_pkg::*;

  localparam int unsigned CoordBits = 20;
  localparam int unsigned MaxObs    = 64;
  localparam int          NumRandom = 228;
  localparam longint      CycleLimit = 60000000;

  typedef struct {
    logic                        op;
    logic [5:0]                  slot;
    logic signed [CoordBits-1:0] ox;
    logic signed [CoordBits-1:0] oy;
    logic [15:0]                 orad;
    logic signed [CoordBits-1:0] sx;
    logic signed [CoordBits-1:0] sy;
  } grow_req_t;

  typedef struct {
    logic signed [CoordBits-1:0] x_min;
    logic signed [CoordBits-1:0] x_max;
    logic signed [CoordBits-1:0] y_min;
    logic signed [CoordBits-1:0] y_max;
    logic                        grew;
  } box_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CfgAddrBits-1:0] paddr = '0;
  logic [CfgDataBits-1:0] pwdata = '0;
  logic [CfgDataBits-1:0] prdata;
  logic pready;

  sbg_in_if  #(.COORD_BITS(CoordBits)) in_if ();
  sbg_out_if #(.COORD_BITS(CoordBits)) out_if ();

  safe_box_grower #(.MAX_OBSTACLES(MaxObs), .COORD_BITS(CoordBits)) i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_if(in_if.sink), .out_if(out_if.source)
  );

  always #2 clk_i = ~clk_i;

  // Shadow copies of the registers and the obstacle table.
  longint map_w, map_h, veh_r, step_len, side_max, obs_cnt;
  longint tbl_x[MaxObs], tbl_y[MaxObs], tbl_r[MaxObs];

  grow_req_t pending_words[$];
  box_t      expected_boxes[$];
  bit        failed = 1'b0;
  bit        calm = 1'b0;     // no idling in the closing stretch
  bit        in_taken = 1'b0; // the presented word was accepted
  longint    cycle_cnt = 0;

  // Inflated-box test against map inset and every counted obstacle.
  function automatic bit box_clear(longint xl, longint yl, longint xh, longint yh);
    longint d;
    longint n;
    if (xl < veh_r || xh > map_w - veh_r || yl < veh_r || yh > map_h - veh_r) return 0;
    n = (obs_cnt > MaxObs) ? MaxObs : obs_cnt;
    for (int k = 0; k < n; k++) begin
      d = tbl_r[k] + veh_r;
      if (xl - d < tbl_x[k] && tbl_x[k] < xh + d && yl - d < tbl_y[k] && tbl_y[k] < yh + d)
        return 0;
    end
    return 1;
  endfunction

  // Apply a word to the shadow state and return the box the block should report.
  function automatic box_t grow_box(grow_req_t w);
    box_t   res;
    longint b[4];        // x_min, y_min, x_max, y_max
    longint t[4];
    longint grown[4];
    bit     live[4];
    int     left;
    side_e  sd;
    res = '{default: 0};
    if (w.op == OpLoad) begin
      tbl_x[w.slot] = w.ox;
      tbl_y[w.slot] = w.oy;
      tbl_r[w.slot] = w.orad;
      res.grew = 1'b1;
      return res;
    end
    b = '{w.sx, w.sy, w.sx, w.sy};
    grown = '{0, 0, 0, 0};
    live = '{1, 1, 1, 1};
    left = 4;
    while (left > 0) begin
      for (int s = 0; s < 4; s++) begin
        if (!live[s]) continue;
        sd = side_e'(s);
        t = b;
        case (sd)
          SidePosY: t[3] += step_len;
          SideNegX: t[0] -= step_len;
          SideNegY: t[1] -= step_len;
          default:  t[2] += step_len;
        endcase
        if (step_len != 0 && box_clear(t[0], t[1], t[2], t[3])) begin
          res.grew = 1'b1;
          grown[s] += step_len;
          b = t;
          if (grown[s] >= side_max) begin
            live[s] = 0;
            left--;
          end
        end else begin
          live[s] = 0;
          left--;
        end
      end
    end
    res.x_min = CoordBits'(b[0]);
    res.x_max = CoordBits'(b[2]);
    res.y_min = CoordBits'(b[1]);
    res.y_max = CoordBits'(b[3]);
    return res;
  endfunction

  // Driver: present queued words at the falling edge, idling in random bursts.
  int in_gap = 0;
  always @(negedge clk_i) begin
    grow_req_t w;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_taken) begin
      // hold the word until it is taken
    end else begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_if.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        w = pending_words[0];
        in_if.valid <= 1'b1;
        in_if.op <= w.op;
        in_if.slot <= w.slot;
        in_if.obstacle_x <= w.ox;
        in_if.obstacle_y <= w.oy;
        in_if.obstacle_radius <= w.orad;
        in_if.seed_x <= w.sx;
        in_if.seed_y <= w.sy;
        if (!calm && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 19);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Predict on acceptance so table loads land in order with queries; retire the word.
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      expected_boxes.push_back(grow_box('{in_if.op, in_if.slot, in_if.obstacle_x,
          in_if.obstacle_y, in_if.obstacle_radius, in_if.seed_x, in_if.seed_y}));
      void'(pending_words.pop_front());
      in_taken = 1'b1;
    end
  end

  // Result side: random stall bursts on ready.
  int out_gap = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if (!calm && $urandom_range(0, 9) == 0) out_gap = $urandom_range(1, 19);
    end
  end

  // Monitor: compare each taken word with the oldest expectation.
  always @(posedge clk_i) begin
    box_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_boxes.size() == 0) begin
        $display("%0t: unexpected box word x[%0d,%0d] y[%0d,%0d] grew %0b", $time,
                 out_if.box_x_min, out_if.box_x_max, out_if.box_y_min,
                 out_if.box_y_max, out_if.grew);
        failed = 1'b1;
      end else begin
        e = expected_boxes.pop_front();
        if (e.x_min !== out_if.box_x_min || e.x_max !== out_if.box_x_max ||
            e.y_min !== out_if.box_y_min || e.y_max !== out_if.box_y_max ||
            e.grew !== out_if.grew) begin
          $display("%0t: box mismatch exp x[%0d,%0d] y[%0d,%0d] grew %0b", $time,
                   e.x_min, e.x_max, e.y_min, e.y_max, e.grew);
          $display("%0t:              got x[%0d,%0d] y[%0d,%0d] grew %0b", $time,
                   out_if.box_x_min, out_if.box_x_max, out_if.box_y_min,
                   out_if.box_y_max, out_if.grew);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // APB write: setup then access, mirrored into the shadow registers.
  task automatic write_reg(logic [2:0] idx, longint val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= CfgAddrBits'(idx) << 2;
    pwdata <= CfgDataBits'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegMapWidth:  map_w    = val & 19'h7ffff;
      RegMapHeight: map_h    = val & 19'h7ffff;
      RegVehRadius: veh_r    = val & 16'hffff;
      RegStepSize:  step_len = val & 16'hffff;
      RegSideLimit: side_max = val & 19'h7ffff;
      default:      obs_cnt  = val & 7'h7f;
    endcase
  endtask

  // Drain results, then let a skipped-result query finish before touching registers.
  task automatic settle();
    while (pending_words.size() > 0 || in_if.valid || expected_boxes.size() > 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic queue_load(int s, longint x, longint y, longint r);
    pending_words.push_back('{OpLoad, s[5:0], CoordBits'(x), CoordBits'(y), 16'(r),
                              CoordBits'($urandom), CoordBits'($urandom)});
  endtask

  task automatic queue_grow(longint x, longint y);
    pending_words.push_back('{OpGrow, 6'($urandom), CoordBits'($urandom),
                              CoordBits'($urandom), 16'($urandom),
                              CoordBits'(x), CoordBits'(y)});
  endtask

  task automatic fill_table();
    for (int s = 0; s < MaxObs; s++)
      queue_load(s, $urandom_range(0, 25600), $urandom_range(0, 25600),
                 $urandom_range(0, 1200));
  endtask

  initial begin
    in_if.valid = 1'b0; in_if.op = OpLoad; in_if.slot = '0;
    in_if.obstacle_x = '0; in_if.obstacle_y = '0; in_if.obstacle_radius = '0;
    in_if.seed_x = '0; in_if.seed_y = '0;
    out_if.ready = 1'b0;
    map_w = 25600; map_h = 25600; veh_r = 256; step_len = 26; side_max = 1280; obs_cnt = 0;
    foreach (tbl_x[k]) begin tbl_x[k] = 0; tbl_y[k] = 0; tbl_r[k] = 0; end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, field extremes, then a dense table.
    queue_grow(12800, 12800);
    queue_grow(-524288, 524287);
    queue_grow(524287, -524288);
    queue_load(0, -524288, 524287, 16'hffff);
    queue_load(1, 524287, -524288, 0);
    queue_load(63, 12800, 12800, 100);
    settle();
    write_reg(RegObsCount, 2);
    queue_grow(12800, 12800);
    settle();
    fill_table();
    settle();
    write_reg(RegObsCount, 64);
    queue_grow(12800, 12800);
    queue_grow(300, 300);
    settle();
    write_reg(RegObsCount, 127);   // saturates to the table size
    write_reg(RegStepSize, 0);     // every trial rejected
    queue_grow(12800, 12800);
    settle();
    write_reg(RegStepSize, 65535);
    write_reg(RegSideLimit, 0);
    write_reg(RegMapWidth, 524287);
    write_reg(RegMapHeight, 524287);
    write_reg(RegVehRadius, 0);
    write_reg(RegObsCount, 0);
    queue_grow(200000, 200000);
    queue_grow(0, 0);
    settle();

    // Random phases, each with its own setting; small limits keep queries short.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(RegMapWidth, ph == 5 ? 0 : $urandom_range(2000, 30000));
      write_reg(RegMapHeight, ph == 5 ? 524287 : $urandom_range(2000, 30000));
      write_reg(RegVehRadius, ph == 4 ? 65535 : $urandom_range(0, 600));
      write_reg(RegStepSize, ph == 3 ? 1 : $urandom_range(8, 400));
      write_reg(RegSideLimit, ph == 3 ? 40 : $urandom_range(0, 3000));
      write_reg(RegObsCount, $urandom_range(0, 64));
      if (ph == 5) calm = 1'b1;
      for (int i = 0; i < NumRandom / 6; i++) begin
        if ($urandom_range(0, 3) == 0)
          queue_load($urandom_range(0, 63),
                     $urandom_range(0, 3) == 0 ? $signed($urandom) >>> 12
                                               : $urandom_range(0, 30000),
                     $urandom_range(0, 3) == 0 ? $signed($urandom) >>> 12
                                               : $urandom_range(0, 30000),
                     $urandom_range(0, 4) == 0 ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 1500));
        else
          queue_grow($urandom_range(0, 7) == 0 ? $signed($urandom) >>> 12
                                               : $urandom_range(0, 30000),
                     $urandom_range(0, 7) == 0 ? $signed($urandom) >>> 12
                                               : $urandom_range(0, 30000));
      end
      settle();
    end

    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
